### hdl/rsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfe_pkg
// Shared types and constants of the range scan flank extraction block.
// ----------------------------------------------------------------------------
package rsfe_pkg;

    localparam int RANGE_W         = 16;
    localparam int SMOOTH_W        = RANGE_W + 1;   // half-millimetre units
    localparam int IDX_W           = 11;
    localparam int RES_MAX         = 4;             // results of one item, at most
    localparam int NUM_W           = 3;             // holds 0 .. RES_MAX
    localparam int OUTQ_DEPTH      = 8;
    localparam int MAX_SAMPLES_DEF = 2048;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 2;

    localparam logic [RANGE_W-1:0] THR_RESET = 16'd100;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_RISE = 2'd1,
        DIR_FALL = 2'd2
    } t_dir;

    typedef struct packed {
        logic             is_summary;
        logic             rising;
        logic [IDX_W-1:0] start_index;
        logic [IDX_W-1:0] end_index;
        logic [IDX_W-1:0] flank_total;
        logic             last_of_run;
    } t_result;

endpackage

### hdl/rsfe_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfe_core
// Scan state, 2-tap smoothing and flank judging, one item per cycle on i_fire.
// ----------------------------------------------------------------------------
module rsfe_core
    import rsfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [RANGE_W-1:0]           i_range_mm,
    input  logic                         i_scan_last,
    input  logic [RANGE_W-1:0]           i_threshold,
    output t_result [RES_MAX-1:0]        o_res,
    output logic [NUM_W-1:0]             o_num
);

    localparam int IW = $clog2(MAX_SAMPLES);

    typedef struct packed {
        logic             open;
        logic [IW-1:0]    start_idx;
        logic [IW-1:0]    last_idx;
        logic             rising;
        t_dir             pdir;
        logic [IDX_W-1:0] evt;
    } t_run;

    typedef struct packed {
        t_run    st;
        logic    emit;
        t_result res;
    } t_judge;

    logic [RANGE_W-1:0]  r_raw1,   n_raw1;
    logic [SMOOTH_W-1:0] r_smooth, n_smooth;
    logic [IW-1:0]       r_count,  n_count;
    logic [1:0]          r_fill,   n_fill;
    t_run                r_run,    n_run;

    function automatic logic [IW-1:0] idx_inc(logic [IW-1:0] idx);
        return (idx == IW'(MAX_SAMPLES - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [IW-1:0] idx_dec(logic [IW-1:0] idx);
        return (idx == '0) ? IW'(MAX_SAMPLES - 1) : idx - 1'b1;
    endfunction

    function automatic t_judge judge(t_run st, logic [IW-1:0] idx,
                                     logic [SMOOTH_W-1:0] cur,
                                     logic [SMOOTH_W-1:0] prev,
                                     logic [RANGE_W-1:0] thr);
        t_judge              jr;
        logic [SMOOTH_W:0]   dlt;
        logic [SMOOTH_W-1:0] mag;
        t_dir                dir;
        jr      = '0;
        jr.st   = st;
        dlt     = {1'b0, cur} - {1'b0, prev};
        mag     = dlt[SMOOTH_W] ? SMOOTH_W'(~dlt + 1'b1) : dlt[SMOOTH_W-1:0];
        dir     = DIR_NONE;
        if (mag > {thr, 1'b0}) begin
            dir = dlt[SMOOTH_W] ? DIR_FALL : DIR_RISE;
        end
        // close the open event when the flank stops or turns
        if (st.open && (dir == DIR_NONE || dir != st.pdir)) begin
            jr.emit            = 1'b1;
            jr.res.rising      = st.rising;
            jr.res.start_index = IDX_W'(st.start_idx);
            jr.res.end_index   = IDX_W'(st.last_idx);
            jr.st.open         = 1'b0;
        end
        if (dir != DIR_NONE) begin
            if (jr.st.open) begin
                jr.st.last_idx = idx;
            end else begin
                jr.st.open      = 1'b1;
                jr.st.start_idx = idx_dec(idx);
                jr.st.last_idx  = idx;
                jr.st.rising    = (dir == DIR_RISE);
                jr.st.evt       = jr.st.evt + 1'b1;
            end
        end
        jr.st.pdir = dir;
        return jr;
    endfunction

    always_comb begin
        t_run                v;
        t_judge              jr;
        logic [SMOOTH_W-1:0] s;
        logic [NUM_W-1:0]    n;
        t_result [RES_MAX-1:0] res;
        v        = r_run;
        jr       = '0;
        s        = '0;
        n        = '0;
        res      = '0;
        n_raw1   = r_raw1;
        n_smooth = r_smooth;
        n_count  = r_count;
        n_fill   = r_fill;
        if (i_fire) begin
            if (!i_scan_last) begin
                if (r_fill != 2'd0) begin
                    s = {1'b0, r_raw1} + {1'b0, i_range_mm};
                    if (r_fill == 2'd2) begin
                        jr = judge(v, idx_dec(r_count), s, r_smooth, i_threshold);
                        v  = jr.st;
                        if (jr.emit) begin
                            res[n[1:0]] = jr.res;
                            n = n + 1'b1;
                        end
                    end
                    n_smooth = s;
                end
                n_raw1  = i_range_mm;
                n_fill  = (r_fill == 2'd2) ? r_fill : r_fill + 1'b1;
                n_count = idx_inc(r_count);
            end else begin
                // last sample: the final two samples pass raw
                if (r_fill == 2'd2) begin
                    jr = judge(v, idx_dec(r_count), {r_raw1, 1'b0}, r_smooth,
                               i_threshold);
                    v  = jr.st;
                    if (jr.emit) begin
                        res[n[1:0]] = jr.res;
                        n = n + 1'b1;
                    end
                end
                if (r_fill != 2'd0) begin
                    jr = judge(v, r_count, {i_range_mm, 1'b0}, {r_raw1, 1'b0},
                               i_threshold);
                    v  = jr.st;
                    if (jr.emit) begin
                        res[n[1:0]] = jr.res;
                        n = n + 1'b1;
                    end
                end
                if (v.open) begin
                    res[n[1:0]].rising      = v.rising;
                    res[n[1:0]].start_index = IDX_W'(v.start_idx);
                    res[n[1:0]].end_index   = IDX_W'(v.last_idx);
                    n = n + 1'b1;
                end
                res[n[1:0]].is_summary  = 1'b1;
                res[n[1:0]].flank_total = v.evt;
                res[n[1:0]].last_of_run = 1'b1;
                n = n + 1'b1;
                // clear all scan state
                v        = '0;
                n_raw1   = '0;
                n_smooth = '0;
                n_count  = '0;
                n_fill   = '0;
            end
        end
        n_run = v;
        o_res = res;
        o_num = n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw1   <= '0;
            r_smooth <= '0;
            r_count  <= '0;
            r_fill   <= '0;
            r_run    <= '0;
        end else begin
            r_raw1   <= n_raw1;
            r_smooth <= n_smooth;
            r_count  <= n_count;
            r_fill   <= n_fill;
            r_run    <= n_run;
        end
    end

endmodule

### hdl/rsfe_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfe_outq
// Result queue: takes up to four results per cycle, hands out one per cycle while i_pop is high.
// ----------------------------------------------------------------------------
module rsfe_outq
    import rsfe_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_result [RES_MAX-1:0] i_push_data,
    input  logic [NUM_W-1:0]      i_push_num,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_data,
    output logic                  o_space
);

    localparam int PTR_W = $clog2(OUTQ_DEPTH);
    localparam int CNT_W = PTR_W + 1;

    t_result          r_mem [OUTQ_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             pop_ok;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop_ok  = i_pop && o_valid;
    // room for a worst-case item, whatever leaves this cycle
    assign o_space = (r_count <= CNT_W'(OUTQ_DEPTH - RES_MAX));

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < RES_MAX; j++) begin
            if (NUM_W'(j) < i_push_num) begin
                r_mem[r_wr_ptr + PTR_W'(j)] <= i_push_data[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PTR_W'(i_push_num);
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CNT_W'(i_push_num) - CNT_W'(pop_ok);
        end
    end

endmodule

### hdl/range_scan_flank_extraction.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scan_flank_extraction
// Smooths a laser range scan and reports merged range flanks per scan.
// Path: an accepted item is registered at the input, judged by the core once
// the output queue has room; the queue offers its results after earlier ones.
// Throughput: one item per cycle while the queue has room; the final item of a
// scan adds up to four results, drained one per cycle while i_ready is high.
// Reset: synchronous, active low; clears scan state and sets the threshold
// to 100 mm.
// ----------------------------------------------------------------------------
module range_scan_flank_extraction
    import rsfe_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [RANGE_W-1:0]    i_range_mm,
    input  logic                  i_scan_last,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_is_summary,
    output logic                  o_rising,
    output logic [IDX_W-1:0]      o_start_index,
    output logic [IDX_W-1:0]      o_end_index,
    output logic [IDX_W-1:0]      o_flank_total,
    output logic                  o_last_of_run
);

    logic [RANGE_W-1:0]    r_threshold;
    logic                  r_in_valid;
    logic [RANGE_W-1:0]    r_in_range;
    logic                  r_in_last;
    logic                  fire;
    logic                  space;
    t_result [RES_MAX-1:0] res;
    logic [NUM_W-1:0]      res_num;
    t_result               head;

    // single register; every address maps onto it
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'({paddr[0] & 1'b0, r_threshold});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RESET;
        end else if (psel && penable && pwrite && pready) begin
            r_threshold <= pwdata[RANGE_W-1:0];
        end
    end

    assign fire    = r_in_valid && space;
    assign o_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_range <= i_range_mm;
            r_in_last  <= i_scan_last;
        end
    end

    rsfe_core #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_range_mm  (r_in_range),
        .i_scan_last (r_in_last),
        .i_threshold (r_threshold),
        .o_res       (res),
        .o_num       (res_num)
    );

    rsfe_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_data (res),
        .i_push_num  (res_num),
        .i_pop       (i_ready),
        .o_valid     (o_valid),
        .o_data      (head),
        .o_space     (space)
    );

    assign o_is_summary  = head.is_summary;
    assign o_rising      = head.rising;
    assign o_start_index = head.start_index;
    assign o_end_index   = head.end_index;
    assign o_flank_total = head.flank_total;
    assign o_last_of_run = head.last_of_run;

endmodule

### verif/rsfe_flank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsfe_flank_checker
// Watches the sample channel, the result channel and the register port of the
// flank extractor. Keeps its own model of the smoothing and flank merging,
// queues the events and summaries each accepted sample should produce, and
// compares every returned item in order against that queue.
// ----------------------------------------------------------------------------
module rsfe_flank_checker
    import rsfe_pkg::*;
#(
    parameter logic [APB_ADDR_W-1:0] THR_ADDR = '0
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [APB_ADDR_W-1:0] i_paddr,
    input  logic [APB_DATA_W-1:0] i_pwdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [RANGE_W-1:0]    i_range_mm,
    input  logic                  i_scan_last,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic                  i_is_summary,
    input  logic                  i_rising,
    input  logic [IDX_W-1:0]      i_start_index,
    input  logic [IDX_W-1:0]      i_end_index,
    input  logic [IDX_W-1:0]      i_flank_total,
    input  logic                  i_last_of_run,
    output int                    o_mismatches,
    output int                    o_pending
);

    localparam int MAX_REPORTS = 10;

    logic [RANGE_W-1:0]  jump_thr;
    logic [RANGE_W-1:0]  last_range;
    logic [SMOOTH_W-1:0] smooth_last;
    logic [IDX_W-1:0]    next_idx;
    logic [1:0]          seen;          // samples of the scan so far, saturating at 2
    t_dir                last_dir;
    logic                run_busy;
    logic [IDX_W-1:0]    run_first;
    logic [IDX_W-1:0]    run_last;
    logic                run_up;
    logic [IDX_W-1:0]    events;
    t_result             flank_q[$];

    function automatic string describe(input t_result item);
        return $sformatf("summary=%0d rising=%0d start=%0d end=%0d total=%0d last=%0d",
                         item.is_summary, item.rising, item.start_index,
                         item.end_index, item.flank_total, item.last_of_run);
    endfunction

    task automatic clear_scan();
        last_range  = '0;
        smooth_last = '0;
        next_idx    = '0;
        seen        = '0;
        last_dir    = DIR_NONE;
        run_busy    = 1'b0;
        run_first   = '0;
        run_last    = '0;
        run_up      = 1'b0;
        events      = '0;
    endtask

    task automatic close_run();
        t_result ev;
        ev             = '0;
        ev.rising      = run_up;
        ev.start_index = run_first;
        ev.end_index   = run_last;
        flank_q        = {flank_q, ev};
        run_busy = 1'b0;
    endtask

    // cur and prv are smoothed values in half-millimetres
    task automatic rate_flank(input logic [IDX_W-1:0] idx, input logic [SMOOTH_W-1:0] cur,
                              input logic [SMOOTH_W-1:0] prv);
        int   delta;
        t_dir dir;
        delta = int'(cur) - int'(prv);
        dir   = DIR_NONE;
        if (delta > 2 * int'(jump_thr))
            dir = DIR_RISE;
        else if (-delta > 2 * int'(jump_thr))
            dir = DIR_FALL;
        // a quiet index or a turn of direction closes the open event
        if (run_busy && (dir == DIR_NONE || dir != last_dir))
            close_run();
        if (dir != DIR_NONE) begin
            if (run_busy) begin
                run_last = idx;
            end else begin
                run_busy  = 1'b1;
                run_first = idx - 1'b1;
                run_last  = idx;
                run_up    = (dir == DIR_RISE);
                events    = events + 1'b1;
            end
        end
        last_dir = dir;
    endtask

    task automatic predict_sample(input logic [RANGE_W-1:0] r, input logic last);
        logic [SMOOTH_W-1:0] mean2;
        t_result             summary;
        if (!last) begin
            if (seen != 2'd0) begin
                mean2 = SMOOTH_W'(last_range) + SMOOTH_W'(r);
                if (seen == 2'd2)
                    rate_flank(next_idx - 1'b1, mean2, smooth_last);
                smooth_last = mean2;
            end
            last_range = r;
            if (seen != 2'd2)
                seen = seen + 1'b1;
            next_idx = next_idx + 1'b1;
        end else begin
            // the final two samples pass raw: judge both remaining indices now
            if (seen == 2'd2)
                rate_flank(next_idx - 1'b1, {last_range, 1'b0}, smooth_last);
            if (seen != 2'd0)
                rate_flank(next_idx, {r, 1'b0}, {last_range, 1'b0});
            if (run_busy)
                close_run();
            summary             = '0;
            summary.is_summary  = 1'b1;
            summary.flank_total = events;
            summary.last_of_run = 1'b1;
            flank_q             = {flank_q, summary};
            clear_scan();
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            jump_thr = THR_RESET;
            clear_scan();
            flank_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == THR_ADDR)
                jump_thr = i_pwdata[RANGE_W-1:0];
            if (i_in_valid && i_in_ready)
                predict_sample(i_range_mm, i_scan_last);
            if (i_out_valid && i_out_ready) begin
                got.is_summary  = i_is_summary;
                got.rising      = i_rising;
                got.start_index = i_start_index;
                got.end_index   = i_end_index;
                got.flank_total = i_flank_total;
                got.last_of_run = i_last_of_run;
                if (flank_q.size() == 0) begin
                    if (o_mismatches < MAX_REPORTS)
                        $display("%0t: unexpected result item: %s", $realtime, describe(got));
                    o_mismatches++;
                end else begin
                    want = flank_q.pop_front();
                    if (got !== want) begin
                        if (o_mismatches < MAX_REPORTS)
                            $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                                     $realtime, describe(want), describe(got));
                        o_mismatches++;
                    end
                end
            end
        end
        o_pending = flank_q.size();
    end

endmodule

### verif/range_scan_flank_extraction_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_scan_flank_extraction_test
// Drives scans of range samples into the flank extractor and sets the jump
// threshold over the register port between scans. Directed scans cover the
// short-scan and boundary cases; random scans mix plateaus, ramps and noise
// under several thresholds, and comb scans give long runs of merged events
// back to back. Both channels idle at random; the checker beside the block
// predicts and compares every result item.
// ----------------------------------------------------------------------------
module range_scan_flank_extraction_test;
    import rsfe_pkg::*;

    // register 0 at byte address 0
    localparam logic [APB_ADDR_W-1:0] REG_JUMP_THRESHOLD = '0;
    localparam int SETTLE_CYCLES  = 6;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int LIMIT_NS       = 10_000_000;

    typedef enum int {
        GAP_NONE,
        GAP_SHORT,
        GAP_ANY
    } t_gap_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [RANGE_W-1:0]    i_range_mm  = '0;
    logic                  i_scan_last = 1'b0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic                  o_is_summary;
    logic                  o_rising;
    logic [IDX_W-1:0]      o_start_index;
    logic [IDX_W-1:0]      o_end_index;
    logic [IDX_W-1:0]      o_flank_total;
    logic                  o_last_of_run;

    int mismatches;
    int pending;
    int cur_thr     = THR_RESET;
    int holdoff_cnt = 0;
    int scan_buf[$];

    range_scan_flank_extraction dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_range_mm    (i_range_mm),
        .i_scan_last   (i_scan_last),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_is_summary  (o_is_summary),
        .o_rising      (o_rising),
        .o_start_index (o_start_index),
        .o_end_index   (o_end_index),
        .o_flank_total (o_flank_total),
        .o_last_of_run (o_last_of_run)
    );

    rsfe_flank_checker #(
        .THR_ADDR (REG_JUMP_THRESHOLD)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_range_mm    (i_range_mm),
        .i_scan_last   (i_scan_last),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_is_summary  (o_is_summary),
        .i_rising      (o_rising),
        .i_start_index (o_start_index),
        .i_end_index   (o_end_index),
        .i_flank_total (o_flank_total),
        .i_last_of_run (o_last_of_run),
        .o_mismatches  (mismatches),
        .o_pending     (pending)
    );

    always #6 i_clk = ~i_clk;

    function automatic int pick_gap(input t_gap_mode mode);
        int roll;
        roll = $urandom_range(0, 99);
        if (mode == GAP_NONE || roll < 50)
            return 0;
        if (roll < 85 || mode == GAP_SHORT)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic int clamp_range(input int val);
        return (val < 0) ? 0 : ((val > 65535) ? 65535 : val);
    endfunction

    // result sink: random stalls, plus a long hold-off on request
    initial begin : sink
        int stall_left;
        int run_left;
        int holdoff_seen;
        stall_left   = 0;
        run_left     = 0;
        holdoff_seen = 0;
        forever begin
            @(posedge i_clk);
            if (holdoff_seen != holdoff_cnt) begin
                holdoff_seen = holdoff_cnt;
                stall_left   = HOLDOFF_CYCLES;
            end
            if (stall_left == 0 && run_left == 0) begin
                stall_left = pick_gap(GAP_ANY);
                run_left   = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
                i_ready <= 1'b0;
                stall_left--;
            end else begin
                i_ready <= 1'b1;
                run_left--;
            end
        end
    end

    task automatic push_sample(input logic [RANGE_W-1:0] r, input logic last,
                               input t_gap_mode mode);
        int gap;
        gap = pick_gap(mode);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_range_mm  <= r;
        i_scan_last <= last;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_scan_buf(input t_gap_mode mode);
        foreach (scan_buf[i])
            push_sample(scan_buf[i][RANGE_W-1:0], i == scan_buf.size() - 1, mode);
    endtask

    // drop valid and hold until every expected item is back
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [RANGE_W-1:0] thr);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_JUMP_THRESHOLD;
        pwdata  <= APB_DATA_W'(thr);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_thr = thr;
    endtask

    // levels low,low,high,high repeated: two merged flanks every four samples
    task automatic send_comb_scan(input int len, input t_gap_mode mode);
        int step_mm;
        int base_mm;
        int k;
        step_mm = $urandom_range(2 * cur_thr + 200, 60000);
        base_mm = $urandom_range(0, 65535 - 50 - step_mm);
        scan_buf.delete();
        for (k = 0; k < len; k++)
            scan_buf = {scan_buf, base_mm + (((k % 4) >= 2) ? step_mm : 0)
                                  + int'($urandom_range(0, 50))};
        send_scan_buf(mode);
    endtask

    task automatic send_random_scans(input int budget);
        int sent;
        int len;
        int roll;
        int shape;
        int level;
        int slope;
        int val;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                len = 1;
            else if (roll < 15)
                len = 2;
            else if (roll < 22)
                len = 3;
            else
                len = $urandom_range(4, 24);
            shape = $urandom_range(0, 9);
            level = $urandom_range(0, 65535);
            slope = 0;
            scan_buf.delete();
            repeat (len) begin
                if (shape >= 8) begin
                    // jitter around the threshold
                    val = level + int'($urandom_range(0, 2 * cur_thr + 2)) - cur_thr - 1;
                end else if (shape >= 6) begin
                    val = $urandom_range(0, 65535);
                end else begin
                    roll = $urandom_range(0, 99);
                    if (roll < 15) begin
                        level = $urandom_range(0, 65535);
                    end else if (roll < 30) begin
                        slope = int'($urandom_range(0, 4 * cur_thr + 64));
                        if ($urandom_range(0, 1))
                            slope = -slope;
                    end else if (roll < 40) begin
                        slope = 0;
                    end
                    level = clamp_range(level + slope);
                    val   = level + int'($urandom_range(0, 3));
                end
                scan_buf = {scan_buf, clamp_range(val)};
            end
            send_scan_buf(GAP_ANY);
            sent += len;
        end
    endtask

    initial begin : stimulus
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short scans and boundaries under the reset threshold
        scan_buf = '{65535};
        send_scan_buf(GAP_ANY);
        scan_buf = '{0, 65535};
        send_scan_buf(GAP_ANY);
        scan_buf = '{0, 65535, 0};
        send_scan_buf(GAP_ANY);
        scan_buf = '{1000, 1000, 1500, 2000, 2500, 2500, 2000, 1000, 1000, 65535};
        send_scan_buf(GAP_ANY);
        scan_buf = '{65535, 0, 65535, 0, 65535};
        send_scan_buf(GAP_ANY);
        // jump of exactly the threshold: no flank
        scan_buf = '{1000, 1000, 1200, 1200};
        send_scan_buf(GAP_ANY);

        wait_idle();
        write_threshold(16'd0);
        send_random_scans(50);

        wait_idle();
        write_threshold(16'hFFFF);
        send_random_scans(40);

        // fill the block while the sink holds off
        wait_idle();
        write_threshold(16'($urandom_range(50, 2000)));
        holdoff_cnt++;
        send_comb_scan(40, GAP_NONE);
        send_random_scans(50);

        // comb scan at a fixed threshold with short gaps
        wait_idle();
        write_threshold(16'd600);
        send_comb_scan(40, GAP_SHORT);

        wait_idle();
        write_threshold(16'($urandom_range(0, 65535)));
        send_random_scans(50);

        wait_idle();
        write_threshold(16'($urandom_range(1, 400)));
        send_random_scans(50);

        wait_idle();
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

endmodule
